[rtl/ltc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared constants, reserved word table and types of the token classifier.
// ----------------------------------------------------------------------------
package ltc_pkg;

  localparam int unsigned LengthLimitDef = 255;

  localparam int unsigned NumRsv  = 13;
  localparam int unsigned RsvMaxLen = 5;

  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7a;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5a;

  typedef enum logic [3:0] {
    CLS_SUM   = 4'd0,
    CLS_TYPE  = 4'd1,
    CLS_MUL   = 4'd2,
    CLS_REL   = 4'd3,
    CLS_OR    = 4'd4,
    CLS_AND   = 4'd5,
    CLS_IDENT = 4'd6,
    CLS_INT   = 4'd7,
    CLS_REAL  = 4'd8,
    CLS_UNREC = 4'd9
  } token_class_e;

  localparam logic [7:0] RsvText [NumRsv][RsvMaxLen] = '{
    '{8'h2b, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2d, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h69, 8'h6e, 8'h74, 8'h00, 8'h00},
    '{8'h66, 8'h6c, 8'h6f, 8'h61, 8'h74},
    '{8'h76, 8'h6f, 8'h69, 8'h64, 8'h00},
    '{8'h2a, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2f, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3c, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3c, 8'h3d, 8'h00, 8'h00, 8'h00},
    '{8'h3e, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3e, 8'h3d, 8'h00, 8'h00, 8'h00},
    '{8'h7c, 8'h7c, 8'h00, 8'h00, 8'h00},
    '{8'h26, 8'h26, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] RsvLen [NumRsv] = '{
    3'd1, 3'd1, 3'd3, 3'd5, 3'd4, 3'd1, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd2
  };

  localparam token_class_e RsvCls [NumRsv] = '{
    CLS_SUM, CLS_SUM, CLS_TYPE, CLS_TYPE, CLS_TYPE, CLS_MUL, CLS_MUL,
    CLS_REL, CLS_REL, CLS_REL, CLS_REL, CLS_OR, CLS_AND
  };

  typedef struct packed {
    logic         hit;
    token_class_e cls;
    logic [7:0]   len;
  } scan_res_t;

endpackage

[rtl/ltc_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_in_reg
// Input register holding one character beat until the scanner takes it.
// ----------------------------------------------------------------------------
module ltc_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] char_i,
  input  logic       eol_i,
  input  logic       adv_i,
  output logic       valid_o,
  output logic [7:0] char_o,
  output logic       eol_o
);

  logic       valid_q, valid_d;
  logic [7:0] char_q;
  logic       eol_q;
  logic       load;

  assign ready_o = !valid_q || adv_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_i;
      eol_q  <= eol_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign eol_o   = eol_q;

endmodule

[rtl/ltc_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_scan
// Token state (count, reserved candidates, shape flags) and close decision.
// ----------------------------------------------------------------------------
module ltc_scan #(
  parameter int unsigned LENGTH_LIMIT = ltc_pkg::LengthLimitDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          char_i,
  input  logic                eol_i,
  output ltc_pkg::scan_res_t  res_o
);
  import ltc_pkg::*;

  localparam int unsigned CntW = $clog2(LENGTH_LIMIT + 1);

  logic [CntW-1:0]   cnt_q, cnt_d, cnt_t;
  logic [NumRsv-1:0] cand_q, cand_d, cand_t;
  logic              id_q, int_q, real_q, dot_q;
  logic              id_d, int_d, real_d, dot_d;
  logic              id_t, int_t, real_t, dot_t;
  logic              is_space, is_dig, is_let, close;
  logic [16:0]       cnt_wide;
  logic              found;
  token_class_e      cls;

  assign is_space = (char_i == ChSpace);
  assign is_dig   = (char_i >= ChZero) && (char_i <= ChNine);
  assign is_let   = ((char_i >= ChLowA) && (char_i <= ChLowZ)) ||
                    ((char_i >= ChUpA) && (char_i <= ChUpZ));

  // state after taking the character
  always_comb begin
    for (int i = 0; i < NumRsv; i++) begin
      cand_t[i] = cand_q[i] && (cnt_q < CntW'(RsvLen[i])) &&
                  (RsvText[i][cnt_q < CntW'(RsvMaxLen) ? 3'(cnt_q) : 3'd0] == char_i);
    end
    id_t = id_q && ((cnt_q == '0) ? is_let : (is_let || is_dig));
    int_t = int_q && is_dig;
    real_t = real_q;
    dot_t = dot_q;
    if (char_i == ChDot) begin
      if (dot_q) begin
        real_t = 1'b0;
      end
      dot_t = 1'b1;
    end else if (!is_dig) begin
      real_t = 1'b0;
    end
    cnt_t = (cnt_q < CntW'(LENGTH_LIMIT)) ? cnt_q + 1'b1 : cnt_q;
  end

  // classify from the current or taken state
  always_comb begin
    logic [CntW-1:0]   c_cnt;
    logic [NumRsv-1:0] c_cand;
    logic              c_id, c_int, c_real, c_dot;
    c_cnt  = is_space ? cnt_q  : cnt_t;
    c_cand = is_space ? cand_q : cand_t;
    c_id   = is_space ? id_q   : id_t;
    c_int  = is_space ? int_q  : int_t;
    c_real = is_space ? real_q : real_t;
    c_dot  = is_space ? dot_q  : dot_t;
    found = 1'b0;
    cls   = CLS_UNREC;
    for (int i = 0; i < NumRsv; i++) begin
      if (!found && c_cand[i] && (c_cnt == CntW'(RsvLen[i]))) begin
        found = 1'b1;
        cls   = RsvCls[i];
      end
    end
    if (!found) begin
      if (c_id) begin
        cls = CLS_IDENT;
      end else if (c_int) begin
        cls = CLS_INT;
      end else if (c_real && c_dot) begin
        cls = CLS_REAL;
      end else begin
        cls = CLS_UNREC;
      end
    end
    cnt_wide = 17'(c_cnt);
  end

  assign close     = is_space ? (cnt_q != '0) : eol_i;
  assign res_o.hit = close;
  assign res_o.cls = cls;
  assign res_o.len = (cnt_wide > 17'd255) ? 8'hff : cnt_wide[7:0];

  always_comb begin
    cnt_d  = cnt_q;
    cand_d = cand_q;
    id_d   = id_q;
    int_d  = int_q;
    real_d = real_q;
    dot_d  = dot_q;
    if (take_i) begin
      if (is_space || eol_i) begin
        cnt_d  = '0;
        cand_d = '1;
        id_d   = 1'b1;
        int_d  = 1'b1;
        real_d = 1'b1;
        dot_d  = 1'b0;
      end else begin
        cnt_d  = cnt_t;
        cand_d = cand_t;
        id_d   = id_t;
        int_d  = int_t;
        real_d = real_t;
        dot_d  = dot_t;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      cand_q <= '1;
      id_q   <= 1'b1;
      int_q  <= 1'b1;
      real_q <= 1'b1;
      dot_q  <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      cand_q <= cand_d;
      id_q   <= id_d;
      int_q  <= int_d;
      real_q <= real_d;
      dot_q  <= dot_d;
    end
  end

endmodule

[rtl/lexical_token_classifier_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lexical_token_classifier_core
// A closing beat passes the input register, then its result is registered.
// One character per cycle unless a closing beat waits on a full result slot.
// Reset clears the open token, the input register and the result register.
// Classifies space-separated tokens of a line and reports class and length.
// ----------------------------------------------------------------------------
module lexical_token_classifier_core #(
  parameter int unsigned LENGTH_LIMIT = ltc_pkg::LengthLimitDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       end_of_line_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] token_class_o,
  output logic [7:0] token_length_o
);
  import ltc_pkg::*;

  logic         s1_valid, s1_eol, adv;
  logic [7:0]   s1_char;
  scan_res_t    res;
  logic         out_valid_q, out_valid_d;
  token_class_e cls_q;
  logic [7:0]   len_q;
  logic         out_load;

  ltc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .char_i  (char_code_i),
    .eol_i   (end_of_line_i),
    .adv_i   (adv),
    .valid_o (s1_valid),
    .char_o  (s1_char),
    .eol_o   (s1_eol)
  );

  ltc_scan #(
    .LENGTH_LIMIT (LENGTH_LIMIT)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (adv),
    .char_i (s1_char),
    .eol_i  (s1_eol),
    .res_o  (res)
  );

  // a beat with no result never waits for the result slot
  assign adv      = s1_valid && (!res.hit || !out_valid_q || out_ready_i);
  assign out_load = adv && res.hit;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cls_q <= res.cls;
      len_q <= res.len;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign token_class_o  = cls_q;
  assign token_length_o = len_q;

endmodule
